### sv/heater_step_response_sequencer_macros.svh
// Assertion macros for the heater step-response sequencer.
`ifndef HEATER_STEP_RESPONSE_SEQUENCER_MACROS_SVH
`define HEATER_STEP_RESPONSE_SEQUENCER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HSRS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define HSRS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/hsrs_pkg.sv
// Shared types and constants of the heater step-response sequencer.
package hsrs_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HEAT  = 3'd1,
        PH_COOL  = 3'd2,
        PH_DONE  = 3'd3,
        PH_FAULT = 3'd4
    } phase_t;

    localparam logic [2:0] F_NONE    = 3'd0;
    localparam logic [2:0] F_SENSOR  = 3'd1;
    localparam logic [2:0] F_CALIB   = 3'd2;
    localparam logic [2:0] F_HOT     = 3'd3;
    localparam logic [2:0] F_HEAT_TO = 3'd4;
    localparam logic [2:0] F_COOL_TO = 3'd5;
    localparam logic [2:0] F_ABORT   = 3'd6;

    localparam logic [2:0] REG_DUTY      = 3'd0;
    localparam logic [2:0] REG_CUTOFF    = 3'd1;
    localparam logic [2:0] REG_MAX_START = 3'd2;
    localparam logic [2:0] REG_COOL_END  = 3'd3;
    localparam logic [2:0] REG_RATE_INT  = 3'd4;
    localparam logic [2:0] REG_LOG_INT   = 3'd5;
    localparam logic [2:0] REG_HEAT_TO   = 3'd6;
    localparam logic [2:0] REG_COOL_TO   = 3'd7;

    localparam int          DIV_W     = 48;
    localparam logic [16:0] RATE_SCALE = 17'd100000;

    typedef enum logic [3:0] {
        C_IDLE,
        C_CMD,
        C_MUL,
        C_WDIV,
        C_WWAIT,
        C_WSAT,
        C_UPD,
        C_ADIV,
        C_AWAIT,
        C_ASAT,
        C_FIN,
        C_OUT
    } ctl_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic cmd;
        logic mul;
        logic wdiv_start;
        logic wsat;
        logic upd;
        logic adiv_start;
        logic asat;
        logic fin;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_wrate;
        logic need_avg;
        logic div_busy;
    } dp_stat_t;

    typedef struct packed {
        logic [6:0]  duty_pct;
        logic [14:0] cutoff_tenths;
        logic [14:0] max_start_tenths;
        logic [14:0] cool_end_delta_tenths;
        logic [31:0] rate_interval_ms;
        logic [31:0] log_interval_ms;
        logic [31:0] heating_timeout_ms;
        logic [31:0] cooling_timeout_ms;
    } cfg_t;

endpackage

### sv/hsrs_divider.sv
// Iterative signed 48-by-32 divider with 32-bit saturation, one bit per cycle.
module hsrs_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [hsrs_pkg::DIV_W-1:0] dividend,
    input  logic [31:0]                  divisor,
    output logic                         busy,
    output logic signed [31:0]           quotient
);
    import hsrs_pkg::*;

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [32:0]      rem_reg, rem_next;
    logic [31:0]      dsr_reg;
    logic             neg_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic [33:0]      trial;
    logic [DIV_W-1:0] mag;
    logic [DIV_W:0]   sq;

    assign trial = {1'b0, rem_reg[31:0], quo_reg[DIV_W-1]} - {2'b00, dsr_reg};
    assign mag   = dividend[DIV_W-1] ? (~dividend + 1'b1) : dividend;

    always_comb begin
        rem_next = {rem_reg[31:0], quo_reg[DIV_W-1]};
        quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        if (!trial[33]) begin
            rem_next    = trial[32:0];
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(DIV_W);
            quo_reg  <= mag;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
            neg_reg  <= dividend[DIV_W-1];
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Saturate the truncated magnitude quotient.
    always_comb begin
        sq = neg_reg ? ({1'b1, ~quo_reg} + 1'b1) : {1'b0, quo_reg};
        if (!neg_reg && quo_reg > DIV_W'(32'h7FFFFFFF)) begin
            quotient = 32'sh7FFFFFFF;
        end else if (neg_reg && quo_reg > DIV_W'(32'h80000000)) begin
            quotient = 32'sh80000000;
        end else begin
            quotient = sq[31:0];
        end
    end

    assign busy = busy_reg;

endmodule

### sv/hsrs_datapath.sv
// Datapath: session state, checks, rate arithmetic and result assembly.
module hsrs_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  hsrs_pkg::cfg_t      cfg,
    input  logic [71:0]         in_data,
    input  hsrs_pkg::dp_cmd_t   cmd,
    output hsrs_pkg::dp_stat_t  stat,
    output logic [215:0]        out_data
);
    import hsrs_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [2:0]         fault_reg, fault_next;
    logic [31:0]        sess_t_reg, sess_t_next, ph_t_reg, ph_t_next;
    logic [31:0]        rref_t_reg, rref_t_next, log_t_reg, log_t_next;
    logic signed [15:0] rref_v_reg, rref_v_next, start_reg, start_next;
    logic signed [15:0] peak_reg, peak_next;
    logic [15:0]        ovs_reg, ovs_next;
    logic signed [31:0] rate_reg, avg_reg;
    logic [31:0]        sess_cnt_reg, sess_cnt_next, log_cnt_reg, log_cnt_next;
    logic [31:0]        log_el_reg, log_el_next;
    logic               pub_reg, pub_next;

    logic [31:0]        now_reg;
    logic signed [15:0] t_reg;
    logic               vld_reg, cal_reg, sta_reg, sto_reg, hok_reg;

    // Pending window update latched during the command step.
    logic               wneed_reg, aneed_reg, wneed_next, aneed_next;
    logic               cool_go_reg, cool_go_next;
    logic signed [16:0] wdelta_reg, adelta_reg, wdelta_next, adelta_next;
    logic [31:0]        wel_reg, ael_reg, wel_next, ael_next;
    logic signed [DIV_W-1:0] wprod_reg, aprod_reg;
    logic signed [DIV_W-1:0] div_a;
    logic [31:0]        div_b;
    logic               div_start, div_busy;
    logic signed [31:0] div_q;

    hsrs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign div_start = cmd.wdiv_start | cmd.adiv_start;
    assign div_a     = cmd.adiv_start ? aprod_reg : wprod_reg;
    assign div_b     = cmd.adiv_start ? ael_reg : wel_reg;

    logic running_in, running_mid;
    logic signed [16:0] cut_s, maxs_s, cend_s;
    logic [31:0] now;
    logic signed [15:0] t;

    assign now = now_reg;
    assign t   = t_reg;
    assign cut_s  = {2'b00, cfg.cutoff_tenths};
    assign maxs_s = {2'b00, cfg.max_start_tenths};
    assign running_in = (phase_reg == PH_HEAT) || (phase_reg == PH_COOL);

    // Whole tick evaluation except the divisions; rate results land later.
    always_comb begin
        phase_next    = phase_reg;
        fault_next    = fault_reg;
        sess_t_next   = sess_t_reg;
        ph_t_next     = ph_t_reg;
        rref_t_next   = rref_t_reg;
        log_t_next    = log_t_reg;
        rref_v_next   = rref_v_reg;
        start_next    = start_reg;
        peak_next     = peak_reg;
        ovs_next      = ovs_reg;
        sess_cnt_next = sess_cnt_reg;
        log_cnt_next  = log_cnt_reg;
        log_el_next   = log_el_reg;
        pub_next      = 1'b0;
        wneed_next    = 1'b0;
        aneed_next    = 1'b0;
        cool_go_next  = 1'b0;
        wdelta_next   = '0;
        adelta_next   = '0;
        wel_next      = '0;
        ael_next      = '0;
        cend_s        = '0;
        running_mid   = 1'b0;

        if (sto_reg && running_in) begin
            fault_next  = F_ABORT;
            phase_next  = PH_DONE;
            log_cnt_next = log_cnt_reg + 1'b1;
            log_el_next = now - sess_t_reg;
            log_t_next  = now;
            pub_next    = 1'b1;
        end else if (sta_reg && !running_in) begin
            sess_cnt_next = sess_cnt_reg + 1'b1;
            log_cnt_next  = 32'd1;
            sess_t_next   = now;
            ph_t_next     = now;
            rref_t_next   = now;
            rref_v_next   = t;
            start_next    = t;
            peak_next     = t;
            ovs_next      = '0;
            fault_next    = F_NONE;
            log_el_next   = '0;
            log_t_next    = now;
            pub_next      = 1'b1;
            if (!vld_reg) begin
                fault_next = F_SENSOR;
                phase_next = PH_FAULT;
            end else if (!cal_reg) begin
                fault_next = F_CALIB;
                phase_next = PH_FAULT;
            end else if ($signed({t[15], t}) > maxs_s) begin
                fault_next = F_HOT;
                phase_next = PH_FAULT;
            end else if (!hok_reg) begin
                fault_next = F_SENSOR;
                phase_next = PH_FAULT;
            end else begin
                phase_next = PH_HEAT;
            end
        end

        running_mid = (phase_next == PH_HEAT) || (phase_next == PH_COOL);
        if (running_mid) begin
            if (!vld_reg || !cal_reg) begin
                fault_next   = vld_reg ? F_CALIB : F_SENSOR;
                phase_next   = PH_FAULT;
                log_cnt_next = log_cnt_next + 1'b1;
                log_el_next  = now - sess_t_next;
                log_t_next   = now;
                pub_next     = 1'b1;
            end else begin
                if (t > peak_next) begin
                    peak_next = t;
                end
                ovs_next = ($signed({peak_next[15], peak_next}) > cut_s)
                           ? 16'({peak_next[15], peak_next} - cut_s) : 16'd0;
                if ((now - rref_t_next) >= cfg.rate_interval_ms) begin
                    wneed_next  = 1'b1;
                    wdelta_next = {t[15], t} - {rref_v_next[15], rref_v_next};
                    wel_next    = now - rref_t_next;
                    rref_t_next = now;
                    rref_v_next = t;
                end
                if (phase_next == PH_HEAT) begin
                    aneed_next  = 1'b1;
                    adelta_next = {t[15], t} - {start_next[15], start_next};
                    ael_next    = now - sess_t_next;
                    if ($signed({t[15], t}) >= cut_s ||
                        (now - ph_t_next) >= cfg.heating_timeout_ms) begin
                        if ($signed({t[15], t}) < cut_s) begin
                            fault_next = F_HEAT_TO;
                        end
                        phase_next   = PH_COOL;
                        ph_t_next    = now;
                        cool_go_next = 1'b1;
                        rref_t_next  = now;
                        rref_v_next  = t;
                        log_cnt_next = log_cnt_next + 1'b1;
                        log_el_next  = now - sess_t_next;
                        log_t_next   = now;
                        pub_next     = 1'b1;
                    end
                end else begin
                    cend_s = {start_next[15], start_next} + $signed({2'b00,
                             cfg.cool_end_delta_tenths});
                    if ($signed({t[15], t}) <= cend_s) begin
                        phase_next   = PH_DONE;
                        log_cnt_next = log_cnt_next + 1'b1;
                        log_el_next  = now - sess_t_next;
                        log_t_next   = now;
                        pub_next     = 1'b1;
                    end else if ((now - ph_t_next) >= cfg.cooling_timeout_ms) begin
                        fault_next   = F_COOL_TO;
                        phase_next   = PH_DONE;
                        log_cnt_next = log_cnt_next + 1'b1;
                        log_el_next  = now - sess_t_next;
                        log_t_next   = now;
                        pub_next     = 1'b1;
                    end
                end
                if ((phase_next == PH_HEAT || phase_next == PH_COOL) &&
                    ((now - log_t_next) >= cfg.log_interval_ms)) begin
                    log_cnt_next = log_cnt_next + 1'b1;
                    log_el_next  = now - sess_t_next;
                    log_t_next   = now;
                    pub_next     = 1'b1;
                end
            end
        end
    end

    // log_count is set straight to 1 on start, counting the start publish above.

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            fault_reg    <= F_NONE;
            sess_t_reg   <= '0;
            ph_t_reg     <= '0;
            rref_t_reg   <= '0;
            log_t_reg    <= '0;
            rref_v_reg   <= '0;
            start_reg    <= '0;
            peak_reg     <= '0;
            ovs_reg      <= '0;
            rate_reg     <= '0;
            avg_reg      <= '0;
            sess_cnt_reg <= '0;
            log_cnt_reg  <= '0;
            log_el_reg   <= '0;
            pub_reg      <= 1'b0;
            wneed_reg    <= 1'b0;
            aneed_reg    <= 1'b0;
            cool_go_reg  <= 1'b0;
        end else begin
            if (cmd.capture) begin
                now_reg <= in_data[31:0];
                t_reg   <= in_data[47:32];
                vld_reg <= in_data[48];
                cal_reg <= in_data[49];
                sta_reg <= in_data[50];
                sto_reg <= in_data[51];
                hok_reg <= in_data[52];
            end
            if (cmd.cmd) begin
                phase_reg    <= phase_next;
                fault_reg    <= fault_next;
                sess_t_reg   <= sess_t_next;
                ph_t_reg     <= ph_t_next;
                rref_t_reg   <= rref_t_next;
                log_t_reg    <= log_t_next;
                rref_v_reg   <= rref_v_next;
                start_reg    <= start_next;
                peak_reg     <= peak_next;
                ovs_reg      <= ovs_next;
                sess_cnt_reg <= sess_cnt_next;
                log_cnt_reg  <= log_cnt_next;
                log_el_reg   <= log_el_next;
                pub_reg      <= pub_next;
                wneed_reg    <= wneed_next;
                aneed_reg    <= aneed_next;
                cool_go_reg  <= cool_go_next;
                wdelta_reg   <= wdelta_next;
                adelta_reg   <= adelta_next;
                wel_reg      <= wel_next;
                ael_reg      <= ael_next;
                if (sta_reg && !running_in) begin
                    rate_reg <= '0;
                    avg_reg  <= '0;
                end
            end
            if (cmd.wsat) begin
                rate_reg <= (wel_reg == '0) ? 32'sd0 : div_q;
            end
            if (cmd.asat) begin
                avg_reg <= (ael_reg == '0) ? 32'sd0 : div_q;
            end
        end
    end

    // Scale both deltas; one multiplier each, registered.
    logic signed [34:0] wprod_w, aprod_w;
    assign wprod_w = wdelta_reg * $signed({1'b0, RATE_SCALE});
    assign aprod_w = adelta_reg * $signed({1'b0, RATE_SCALE});

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            wprod_reg <= DIV_W'(wprod_w);
            aprod_reg <= DIV_W'(aprod_w);
        end
    end

    assign stat.need_wrate = wneed_reg;
    assign stat.need_avg   = aneed_reg;
    assign stat.div_busy   = div_busy;

    logic [31:0] elapsed;
    assign elapsed = ((phase_reg == PH_HEAT) || (phase_reg == PH_COOL))
                     ? (now_reg - sess_t_reg) : log_el_reg;

    // Fields from the lowest bit: run_state, fault_code, heater_enable,
    // window_rate, average_rate, peak, overshoot, start, log_publish,
    // session_number, log_number, elapsed.
    assign out_data = {elapsed, log_cnt_reg, sess_cnt_reg, pub_reg,
                       start_reg, ovs_reg, peak_reg, avg_reg, rate_reg,
                       (phase_reg == PH_HEAT), fault_reg, phase_reg};

    logic unused_ok;
    assign unused_ok = cmd.upd ^ cmd.fin ^ cool_go_reg ^ (|cfg.duty_pct) ^
                       (|in_data[71:53]);

    `include "heater_step_response_sequencer_macros.svh"
    `HSRS_ASSERT_NXT(a_start_clears_rates, aclk, aresetn,
        cmd.cmd && sta_reg && !running_in && !(sto_reg && running_in),
        rate_reg == 32'sd0 && avg_reg == 32'sd0)
    `HSRS_ASSERT_IMP(a_heat_no_fault_code, aclk, aresetn,
        phase_reg == PH_HEAT, fault_reg == F_NONE)
    `HSRS_ASSERT_IMP(a_one_div_start, aclk, aresetn,
        cmd.wdiv_start, !cmd.adiv_start)

endmodule

### sv/hsrs_ctrl.sv
// Controller: sequences capture, update, multiply, up to two divisions and output.
module hsrs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                out_fire,
    input  hsrs_pkg::dp_stat_t  stat,
    output hsrs_pkg::dp_cmd_t   cmd,
    output logic                in_ready,
    output logic                out_valid
);
    import hsrs_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            C_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_fire;
                if (in_fire) begin
                    state_next = C_CMD;
                end
            end
            C_CMD: begin
                cmd.cmd    = 1'b1;
                state_next = C_MUL;
            end
            C_MUL: begin
                cmd.mul    = 1'b1;
                state_next = C_WDIV;
            end
            C_WDIV: begin
                if (stat.need_wrate) begin
                    cmd.wdiv_start = 1'b1;
                    state_next     = C_WWAIT;
                end else begin
                    state_next = C_UPD;
                end
            end
            C_WWAIT: begin
                if (!stat.div_busy) begin
                    state_next = C_WSAT;
                end
            end
            C_WSAT: begin
                cmd.wsat   = 1'b1;
                state_next = C_UPD;
            end
            C_UPD: begin
                cmd.upd    = 1'b1;
                state_next = C_ADIV;
            end
            C_ADIV: begin
                if (stat.need_avg) begin
                    cmd.adiv_start = 1'b1;
                    state_next     = C_AWAIT;
                end else begin
                    state_next = C_FIN;
                end
            end
            C_AWAIT: begin
                if (!stat.div_busy) begin
                    state_next = C_ASAT;
                end
            end
            C_ASAT: begin
                cmd.asat   = 1'b1;
                state_next = C_FIN;
            end
            C_FIN: begin
                cmd.fin    = 1'b1;
                state_next = C_OUT;
            end
            C_OUT: begin
                out_valid = 1'b1;
                if (out_fire) begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    `include "heater_step_response_sequencer_macros.svh"
    `HSRS_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != C_IDLE, !in_ready)
    `HSRS_ASSERT_NXT(a_wait_after_start, aclk, aresetn, cmd.wdiv_start, state_reg == C_WWAIT)
    `HSRS_ASSERT_NXT(a_out_after_fin, aclk, aresetn, cmd.fin, out_valid)

endmodule

### sv/heater_step_response_sequencer.sv
// Heater step-response sequencer: one tick in, one status result out.
// Both rate divisions run one after the other on one shared divider, and each is skipped when
// no rate update needs it; the next tick is taken only after the result leaves.
// Reset (aresetn low, synchronous): idle phase, configuration registers at defaults, counts zero.
module heater_step_response_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms[31:0], temperature[47:32], sample_valid, sensor_calibrated,
    // start_request, stop_request, heater_start_ok [52:48], zero fill
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // run_state, fault_code, heater_enable, window_rate, average_rate,
    // peak_tenths, overshoot, start_tenths, log_publish, session_number,
    // log_number, elapsed
    output logic [215:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import hsrs_pkg::*;

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.duty_pct              <= 7'd25;
            cfg_reg.cutoff_tenths         <= 15'd1100;
            cfg_reg.max_start_tenths      <= 15'd500;
            cfg_reg.cool_end_delta_tenths <= 15'd30;
            cfg_reg.rate_interval_ms      <= 32'd10000;
            cfg_reg.log_interval_ms       <= 32'd1000;
            cfg_reg.heating_timeout_ms    <= 32'd900000;
            cfg_reg.cooling_timeout_ms    <= 32'd1800000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DUTY:      cfg_reg.duty_pct              <= cfg_data[6:0];
                REG_CUTOFF:    cfg_reg.cutoff_tenths         <= cfg_data[14:0];
                REG_MAX_START: cfg_reg.max_start_tenths      <= cfg_data[14:0];
                REG_COOL_END:  cfg_reg.cool_end_delta_tenths <= cfg_data[14:0];
                REG_RATE_INT:  cfg_reg.rate_interval_ms      <= cfg_data;
                REG_LOG_INT:   cfg_reg.log_interval_ms       <= cfg_data;
                REG_HEAT_TO:   cfg_reg.heating_timeout_ms    <= cfg_data;
                REG_COOL_TO:   cfg_reg.cooling_timeout_ms    <= cfg_data;
                default: ;
            endcase
        end
    end

    hsrs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_tvalid & in_ready),
        .out_fire  (m_tvalid & m_tready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (m_tvalid)
    );

    hsrs_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_data  ({16'd0, s_tdata}),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_tdata)
    );

    assign s_tready = in_ready;

endmodule
